FILE: hw/rtl/fbt_pkg.sv
// Shared types and constants of the Fermat base test block.
// Used by fbt_ctrl, fbt_datapath and fermat_base_test; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fbt_pkg;

    localparam int NUMBER_WIDTH = 64;
    localparam int CNT_W        = $clog2(NUMBER_WIDTH);

    // candidates at or below this limit pass every base
    localparam logic [NUMBER_WIDTH-1:0] SMALL_LIMIT = NUMBER_WIDTH'(1009);

    typedef struct packed {
        logic [63:0] tested_number;
        logic [63:0] base;
        logic        last_base;
    } operand_t;

    typedef struct packed {
        logic base_passes;
        logic all_passed;
        logic verdict_final;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_NORM,
        ST_GCD_STEP,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_MUL_WB,
        ST_EXP_MUL,
        ST_EXP_SQR
    } state_t;

    // which modular product runs, and where its result goes
    typedef enum logic [1:0] {
        MT_RED,
        MT_ACC,
        MT_SQ
    } mul_tgt_t;

    typedef enum logic [1:0] {
        PASS_ONE,
        PASS_FAIL,
        PASS_ACC
    } pass_t;

    typedef struct packed {
        logic     load;
        logic     gcd_shift_u;
        logic     gcd_step;
        logic     mul_start;
        logic     mul_dbl;
        logic     mul_add;
        logic     mul_wb;
        mul_tgt_t mul_sel;
        logic     e_shift;
        logic     finish;
        pass_t    pass_sel;
    } cmd_t;

    typedef struct packed {
        logic cand_small;
        logic both_even;
        logic u_even;
        logic v_zero;
        logic gcd_one;
        logic mul_bit;
        logic mul_last;
        logic e_bit;
        logic e_rest_zero;
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbt_ctrl.sv
// Sequencer of the Fermat base test: small-candidate check, binary gcd,
// shift-add modular products and the square-and-multiply walk. Uses fbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire fbt_pkg::status_t status,
    output fbt_pkg::cmd_t        cmd
);

    fbt_pkg::state_t   state_reg, state_next;
    fbt_pkg::mul_tgt_t tgt_reg, tgt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbt_pkg::ST_IDLE;
            tgt_reg   <= fbt_pkg::MT_RED;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tgt_next     = tgt_reg;
        cmd          = '0;
        cmd.mul_sel  = tgt_reg;
        cmd.pass_sel = fbt_pkg::PASS_ONE;
        case (state_reg)
            fbt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = fbt_pkg::ST_CHECK;
                end
            end
            fbt_pkg::ST_CHECK:
            begin
                if (status.cand_small)
                begin
                    cmd.finish   = 1'b1;
                    cmd.pass_sel = fbt_pkg::PASS_ONE;
                    state_next   = fbt_pkg::ST_IDLE;
                end
                else if (status.both_even)
                begin
                    cmd.finish   = 1'b1;
                    cmd.pass_sel = fbt_pkg::PASS_FAIL;
                    state_next   = fbt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fbt_pkg::ST_GCD_NORM;
                end
            end
            fbt_pkg::ST_GCD_NORM:
            begin
                // strip factors of two from the candidate side
                if (status.u_even)
                begin
                    cmd.gcd_shift_u = 1'b1;
                end
                else
                begin
                    state_next = fbt_pkg::ST_GCD_STEP;
                end
            end
            fbt_pkg::ST_GCD_STEP:
            begin
                if (status.v_zero)
                begin
                    if (status.gcd_one)
                    begin
                        // reduce the base modulo the candidate
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = fbt_pkg::MT_RED;
                        tgt_next      = fbt_pkg::MT_RED;
                        state_next    = fbt_pkg::ST_MUL_DBL;
                    end
                    else
                    begin
                        cmd.finish   = 1'b1;
                        cmd.pass_sel = fbt_pkg::PASS_FAIL;
                        state_next   = fbt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            fbt_pkg::ST_MUL_DBL:
            begin
                cmd.mul_dbl = 1'b1;
                if (status.mul_bit)
                begin
                    state_next = fbt_pkg::ST_MUL_ADD;
                end
                else if (status.mul_last)
                begin
                    state_next = fbt_pkg::ST_MUL_WB;
                end
            end
            fbt_pkg::ST_MUL_ADD:
            begin
                cmd.mul_add = 1'b1;
                if (status.mul_last)
                begin
                    state_next = fbt_pkg::ST_MUL_WB;
                end
                else
                begin
                    state_next = fbt_pkg::ST_MUL_DBL;
                end
            end
            fbt_pkg::ST_MUL_WB:
            begin
                cmd.mul_wb = 1'b1;
                case (tgt_reg)
                    fbt_pkg::MT_ACC: state_next = fbt_pkg::ST_EXP_SQR;
                    default:         state_next = fbt_pkg::ST_EXP_MUL;
                endcase
            end
            fbt_pkg::ST_EXP_MUL:
            begin
                if (status.e_bit)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fbt_pkg::MT_ACC;
                    tgt_next      = fbt_pkg::MT_ACC;
                    state_next    = fbt_pkg::ST_MUL_DBL;
                end
                else
                begin
                    state_next = fbt_pkg::ST_EXP_SQR;
                end
            end
            fbt_pkg::ST_EXP_SQR:
            begin
                // stop once no exponent bits remain above the current one
                if (status.e_rest_zero)
                begin
                    cmd.finish   = 1'b1;
                    cmd.pass_sel = fbt_pkg::PASS_ACC;
                    state_next   = fbt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.e_shift   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = fbt_pkg::MT_SQ;
                    tgt_next      = fbt_pkg::MT_SQ;
                    state_next    = fbt_pkg::ST_MUL_DBL;
                end
            end
            default:
            begin
                state_next = fbt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != fbt_pkg::ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/fbt_datapath.sv
// Datapath of the Fermat base test: operand registers, gcd registers, one
// shared modular adder for the shift-add products, running verdict. Uses fbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbt_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fbt_pkg::operand_t  operand,
    input  wire fbt_pkg::cmd_t      cmd,
    output fbt_pkg::status_t        status,
    output fbt_pkg::result_t        result,
    output logic                    done
);

    localparam int NW = fbt_pkg::NUMBER_WIDTH;
    localparam int CW = fbt_pkg::CNT_W;

    // x + y mod m for x, y < m
    function automatic logic [NW-1:0] add_mod(input logic [NW-1:0] x,
                                              input logic [NW-1:0] y,
                                              input logic [NW-1:0] m);
        logic [NW:0] s;
        logic [NW:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[NW-1:0] : s[NW-1:0];
    endfunction

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] base_reg, base_next;
    logic [NW-1:0] u_reg, u_next;
    logic [NW-1:0] v_reg, v_next;
    logic [NW-1:0] acc_reg, acc_next;
    logic [NW-1:0] sq_reg, sq_next;
    logic [NW-1:0] e_reg, e_next;
    logic [NW-1:0] mx_reg, mx_next;
    logic [NW-1:0] my_reg, my_next;
    logic [NW-1:0] p_reg, p_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          verdict_reg, verdict_next;
    logic          done_reg, done_next;
    fbt_pkg::result_t res_reg, res_next;

    logic [NW-1:0] n_in;
    logic [NW-1:0] base_in;
    logic [NW-1:0] addend;
    logic [NW-1:0] sum;
    logic          pass;
    logic          all;

    assign n_in    = operand.tested_number[NW-1:0];
    assign base_in = operand.base[NW-1:0];

    // doubling and accumulating share one modular adder
    assign addend = cmd.mul_add ? mx_reg : p_reg;
    assign sum    = add_mod(p_reg, addend, n_reg);

    always_comb
    begin
        n_next       = n_reg;
        base_next    = base_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        e_next       = e_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        verdict_next = verdict_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        pass         = 1'b1;
        all          = 1'b1;

        if (cmd.load)
        begin
            n_next    = n_in;
            base_next = base_in;
            u_next    = n_in;
            v_next    = base_in;
            e_next    = n_in - NW'(1);
            acc_next  = NW'(1);
            last_next = operand.last_base;
        end

        if (cmd.gcd_shift_u)
        begin
            u_next = u_reg >> 1;
        end

        if (cmd.gcd_step)
        begin
            if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (u_reg <= v_reg)
            begin
                v_next = v_reg - u_reg;
            end
            else
            begin
                u_next = v_reg;
                v_next = u_reg - v_reg;
            end
        end

        if (cmd.mul_start)
        begin
            p_next   = '0;
            cnt_next = '0;
            case (cmd.mul_sel)
                fbt_pkg::MT_RED:
                begin
                    mx_next = NW'(1);
                    my_next = base_reg;
                end
                fbt_pkg::MT_ACC:
                begin
                    mx_next = acc_reg;
                    my_next = sq_reg;
                end
                default:
                begin
                    mx_next = sq_reg;
                    my_next = sq_reg;
                end
            endcase
        end

        if (cmd.mul_dbl)
        begin
            p_next = sum;
            // advance now unless the multiplier bit still needs its add
            if (!my_reg[NW-1])
            begin
                my_next  = my_reg << 1;
                cnt_next = cnt_reg + CW'(1);
            end
        end

        if (cmd.mul_add)
        begin
            p_next   = sum;
            my_next  = my_reg << 1;
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.mul_wb)
        begin
            case (cmd.mul_sel)
                fbt_pkg::MT_ACC: acc_next = p_reg;
                default:         sq_next  = p_reg;
            endcase
        end

        if (cmd.e_shift)
        begin
            e_next = e_reg >> 1;
        end

        if (cmd.finish)
        begin
            case (cmd.pass_sel)
                fbt_pkg::PASS_ONE:  pass = 1'b1;
                fbt_pkg::PASS_FAIL: pass = 1'b0;
                fbt_pkg::PASS_ACC:  pass = (acc_reg == NW'(1));
                default:            pass = 1'b0;
            endcase
            all                    = verdict_reg & pass;
            res_next.base_passes   = pass;
            res_next.all_passed    = all;
            res_next.verdict_final = last_reg;
            verdict_next           = last_reg ? 1'b1 : all;
            done_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_reg <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            verdict_reg <= verdict_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        base_reg <= base_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        e_reg    <= e_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        p_reg    <= p_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

    assign status.cand_small  = (n_reg <= fbt_pkg::SMALL_LIMIT);
    assign status.both_even   = !n_reg[0] && !base_reg[0];
    assign status.u_even      = !u_reg[0];
    assign status.v_zero      = (v_reg == '0);
    assign status.gcd_one     = (u_reg == NW'(1));
    assign status.mul_bit     = my_reg[NW-1];
    assign status.mul_last    = (cnt_reg == CW'(NW - 1));
    assign status.e_bit       = e_reg[0];
    assign status.e_rest_zero = (e_reg[NW-1:1] == '0);

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fermat_base_test.sv
// Top level of the Fermat base test: joins fbt_ctrl and fbt_datapath.
// Depends on fbt_pkg, fbt_ctrl and fbt_datapath.
//
// Usage:
//   Drive operand (candidate, base, last-base mark) and raise start; the
//   transfer happens at the clock edge where start is high and busy is low.
//   busy stays high while the item is worked on. The result appears on
//   result for exactly one cycle with done high; it cannot be held off.
//   busy is already low in that cycle, so the next item may start then.
// Sequence:
//   Candidates of 1009 or less, or candidate and base both even, are
//   settled in the check state. Otherwise a binary gcd runs, then a
//   reduction of the base and up to 2*NUMBER_WIDTH modular products
//   follow, with a multiply state and a square state per exponent bit.
//   Each product is a shift-add over NUMBER_WIDTH multiplier bits
//   through one shared modular adder: a doubling step per bit, an add
//   step per set bit and a write-back step.
// Reset:
//   Returns to idle and sets the running verdict to all passed.
`timescale 1ns / 1ps
`default_nettype none

module fermat_base_test (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire fbt_pkg::operand_t  operand,
    output fbt_pkg::result_t        result,
    output logic                    done
);

    fbt_pkg::cmd_t    cmd;
    fbt_pkg::status_t status;

    fbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    fbt_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .cmd     (cmd),
        .status  (status),
        .result  (result),
        .done    (done)
    );

    // an accepted item keeps the block busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // result strobes are never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // the block is idle while a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a failing base always clears all_passed in its result
    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.base_passes |-> !result.all_passed)
        else $error("all_passed set by a failing base");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for fermat_base_test: directed and random candidate/base transfers,
// each result checked against an in-bench Fermat predictor. Depends on fbt_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int END_WAIT       = 20;
    localparam int MAX_REPORTS    = 10;

    localparam logic [63:0] MAX64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PRIME64   = 64'hFFFF_FFFF_FFFF_FFC5;  // largest 64-bit prime
    localparam logic [63:0] PRIME32   = 64'd4294967291;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    fbt_pkg::operand_t operand = '0;
    fbt_pkg::result_t  result;
    logic              done;

    fermat_base_test uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .result  (result),
        .done    (done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fbt_pkg::result_t pending_verdicts[$];
    logic        verdict_so_far = 1'b1;
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          quiet_cycles = 0;
    logic [63:0] prime_pool[6] = '{64'd1013, 64'd65537, 64'd1000003, 64'd2147483647,
                                   PRIME32, PRIME64};
    logic [63:0] carmichael_pool[5] = '{64'd1105, 64'd1729, 64'd2465, 64'd41041,
                                        64'd825265};

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] n);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        p = p % {64'd0, n};
        return p[63:0];
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] a, logic [63:0] e,
                                              logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = a % n;
        for (int i = 0; i < 64; i++)
        begin
            if (e[i])
                acc = mod_product(acc, sq, n);
            sq = mod_product(sq, sq, n);
        end
        return acc;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 64'd0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Predict one result and advance the running verdict.
    function automatic fbt_pkg::result_t fermat_verdict(fbt_pkg::operand_t op);
        logic             pass;
        fbt_pkg::result_t r;
        pass = 1'b1;
        if (op.tested_number > fbt_pkg::SMALL_LIMIT)
        begin
            if (gcd64(op.tested_number, op.base) != 64'd1)
                pass = 1'b0;
            else if (mod_power(op.base, op.tested_number - 64'd1, op.tested_number) != 64'd1)
                pass = 1'b0;
        end
        r.base_passes   = pass;
        r.all_passed    = verdict_so_far & pass;
        r.verdict_final = op.last_base;
        verdict_so_far  = op.last_base ? 1'b1 : r.all_passed;
        return r;
    endfunction

    // Hold start high from the step the item is driven until the transfer edge.
    task automatic send_candidate_base(logic [63:0] n, logic [63:0] a, logic last);
        fbt_pkg::operand_t op;
        op.tested_number = n;
        op.base          = a;
        op.last_base     = last;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        operand <= op;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_verdicts.push_back(fermat_verdict(op));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    always @(posedge clk)
    begin
        fbt_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: got %b/%b/%b", result.base_passes,
                             result.all_passed, result.verdict_final);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.base_passes !== want.base_passes ||
                    result.all_passed !== want.all_passed ||
                    result.verdict_final !== want.verdict_final)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch pass/all/final: %s %b/%b/%b %s %b/%b/%b",
                                 "expected", want.base_passes, want.all_passed,
                                 want.verdict_final, "actual", result.base_passes,
                                 result.all_passed, result.verdict_final);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_small_candidates();
        send_candidate_base(64'd0, 64'd0, 1'b0);
        send_candidate_base(64'd1, MAX64, 1'b0);
        send_candidate_base(64'd2, 64'd5, 1'b0);
        send_candidate_base(64'd1009, 64'd0, 1'b0);
        send_candidate_base(64'd1009, MAX64, 1'b1);
    endtask

    task automatic test_known_primes();
        send_candidate_base(64'd1013, 64'd2, 1'b0);
        send_candidate_base(PRIME32, MAX64, 1'b0);
        send_candidate_base(PRIME64, 64'd2, 1'b0);
        send_candidate_base(PRIME64, MAX64, 1'b1);
    endtask

    task automatic test_composites();
        send_candidate_base(64'd1010, 64'd4, 1'b1);          // both even
        send_candidate_base(64'd1011, 64'd2, 1'b1);          // Fermat witness
        send_candidate_base(64'd1105, 64'd2, 1'b0);          // Carmichael, coprime base
        send_candidate_base(64'd1105, 64'd5, 1'b1);          // shared factor
        send_candidate_base(MAX64, 64'd2, 1'b1);
    endtask

    task automatic test_base_edges();
        send_candidate_base(64'd1013, 64'd0, 1'b1);
        send_candidate_base(64'd1013, 64'd1, 1'b0);
        send_candidate_base(64'd1013, 64'd1012, 1'b0);
        send_candidate_base(64'd1013, 64'd1013, 1'b1);       // base equal to candidate
        send_candidate_base(64'd1013, 64'd1015, 1'b1);       // base above candidate
    endtask

    // Drop the verdict mid-run, keep passing bases, then close and start fresh.
    task automatic test_verdict_chain();
        send_candidate_base(64'd1013, 64'd3, 1'b0);
        send_candidate_base(64'd1011, 64'd2, 1'b0);
        send_candidate_base(64'd1013, 64'd5, 1'b0);
        send_candidate_base(64'd1013, 64'd7, 1'b1);
        send_candidate_base(64'd65537, 64'd3, 1'b1);
    endtask

    function automatic logic [63:0] pick_base(logic [63:0] n);
        case ($urandom_range(9))
            6: return 64'($urandom_range(1000, 2));
            7: return n - 64'd1;
            8: return n * 64'($urandom_range(3));
            9: return 64'($urandom_range(1));
            default: return rand64();
        endcase
    endfunction

    task automatic test_random_items(int idle_pct, int count);
        int          sent;
        int          bases;
        int          width;
        logic        noisy;
        logic [63:0] n;
        logic [63:0] a;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < count)
        begin
            case ($urandom_range(9))
                0, 1: n = 64'($urandom_range(1009));
                2, 3: n = rand64() & ~64'd1;
                4, 5: n = prime_pool[$urandom_range(5)];
                6:    n = carmichael_pool[$urandom_range(4)];
                7, 8:
                begin
                    width = $urandom_range(24, 11);
                    n = (rand64() >> (64 - width)) | (64'd1 << (width - 1)) | 64'd1;
                end
                default: n = rand64() | 64'd1;
            endcase
            bases = $urandom_range(4, 1);
            noisy = ($urandom_range(9) == 0);
            for (int b = 0; b < bases; b++)
            begin
                a = pick_base(n);
                // keep even candidates mostly cheap: pair most of them with even bases
                if (!n[0] && n > fbt_pkg::SMALL_LIMIT && $urandom_range(3) != 0)
                    a[0] = 1'b0;
                send_candidate_base(n, a, noisy ? 1'($urandom_range(1)) : (b == bases - 1));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 0;
        test_small_candidates();
        test_known_primes();
        drain_results();
        sender_idle_pct = 62;
        test_composites();
        test_base_edges();
        drain_results();
        sender_idle_pct = 32;
        test_verdict_chain();

        test_random_items(0, 26);
        drain_results();
        test_random_items(62, 25);
        test_random_items(32, 25);

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
